// ===== rtl/core/ssm_pkg.sv =====
`timescale 1ns / 1ps

package ssm_pkg;

    // Defaults for the top level parameters
    localparam int DEF_MAX_ENTITIES   = 1024;
    localparam int DEF_NUM_SYSTEMS    = 4;
    localparam int DEF_SIGNATURE_BITS = 32;

    // Fixed field widths
    localparam int ENT_W   = 10;
    localparam int SIG_W   = 32;
    localparam int SEL_W   = 2;
    localparam int MASK_W  = 4;
    localparam int COUNT_W = 11;
    localparam int CFG_IDX_W = 3;

    // Request types
    localparam logic [1:0] REQ_CHANGE  = 2'd0;
    localparam logic [1:0] REQ_DESTROY = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_LAST = 3'd4;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [ENT_W-1:0] entity_id;
        logic [SIG_W-1:0] old_signature;
        logic [SIG_W-1:0] new_signature;
        logic [SEL_W-1:0] system_index;
        logic [ENT_W-1:0] dense_index;
    } t_in;

    typedef struct packed {
        logic [MASK_W-1:0]  joined_mask;
        logic [MASK_W-1:0]  left_mask;
        logic [MASK_W-1:0]  warn_mask;
        logic [ENT_W-1:0]   read_entity;
        logic               read_valid;
        logic [COUNT_W-1:0] member_count;
    } t_out;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DEC,
        S_WR1,
        S_WR2,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clr;
        logic capture;
        logic look;
        logic dec;
        logic wr1;
        logic wr2;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } t_stat;

endpackage

// ===== rtl/core/ssm_ram.sv =====
`timescale 1ns / 1ps

module ssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ssm_ctrl.sv =====
`timescale 1ns / 1ps

module ssm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ssm_pkg::t_stat i_stat,
    output ssm_pkg::t_cmd  o_cmd
);

    ssm_pkg::t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssm_pkg::S_CLEAR: if (i_stat.clr_last) n_state = ssm_pkg::S_IDLE;
            ssm_pkg::S_IDLE:  if (i_valid) n_state = ssm_pkg::S_LOOK;
            ssm_pkg::S_LOOK:  n_state = ssm_pkg::S_DEC;
            ssm_pkg::S_DEC:   n_state = ssm_pkg::S_WR1;
            ssm_pkg::S_WR1:   n_state = ssm_pkg::S_WR2;
            ssm_pkg::S_WR2:   n_state = ssm_pkg::S_OUT;
            ssm_pkg::S_OUT:   if (!i_stat.out_busy) n_state = ssm_pkg::S_IDLE;
            default:          n_state = ssm_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        o_ready = 1'b0;
        case (r_state)
            ssm_pkg::S_CLEAR: o_cmd.clr = 1'b1;
            ssm_pkg::S_IDLE: begin
                o_ready = 1'b1;
                o_cmd.capture = 1'b1;
            end
            ssm_pkg::S_LOOK:  o_cmd.look = 1'b1;
            ssm_pkg::S_DEC:   o_cmd.dec = 1'b1;
            ssm_pkg::S_WR1:   o_cmd.wr1 = 1'b1;
            ssm_pkg::S_WR2:   o_cmd.wr2 = 1'b1;
            ssm_pkg::S_OUT:   o_cmd.load_out = !i_stat.out_busy;
            default:          o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/ssm_dp.sv =====
`timescale 1ns / 1ps

module ssm_dp #(
    parameter int MAX_ENTITIES   = ssm_pkg::DEF_MAX_ENTITIES,
    parameter int NUM_SYSTEMS    = ssm_pkg::DEF_NUM_SYSTEMS,
    parameter int SIGNATURE_BITS = ssm_pkg::DEF_SIGNATURE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ssm_pkg::t_cmd                  i_cmd,
    output ssm_pkg::t_stat                 o_stat,
    input  ssm_pkg::t_in                   i_data,
    input  logic                           i_cfg_we,
    input  logic [ssm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssm_pkg::SIG_W-1:0]      i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output ssm_pkg::t_out                  o_data
);

    localparam int IW = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int CW = $clog2(MAX_ENTITIES + 1);
    localparam int NS = NUM_SYSTEMS;

    // Signature mask for the low SIGNATURE_BITS bits
    logic [ssm_pkg::SIG_W-1:0] sig_keep;
    always_comb begin
        for (int i = 0; i < ssm_pkg::SIG_W; i++) begin
            sig_keep[i] = (i < SIGNATURE_BITS);
        end
    end

    // Configuration registers
    logic [ssm_pkg::MASK_W-1:0] r_enable;
    logic [ssm_pkg::SIG_W-1:0]  r_sig [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            for (int s = 0; s < NS; s++) r_sig[s] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == ssm_pkg::CFG_ENABLE) begin
                r_enable <= i_cfg_data[ssm_pkg::MASK_W-1:0];
            end
            for (int s = 0; s < NS; s++) begin
                if (i_cfg_index >= ssm_pkg::CFG_SIG_0 && i_cfg_index <= ssm_pkg::CFG_SIG_LAST
                    && 32'(i_cfg_index) == 32'(s + 1)) begin
                    r_sig[s] <= i_cfg_data & sig_keep;
                end
            end
        end
    end

    // Latched request
    ssm_pkg::t_in r_req;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_req <= i_data;
    end

    logic [IW-1:0] ent_ix, didx_ix;
    logic          op_ok;
    assign ent_ix  = IW'(r_req.entity_id);
    assign didx_ix = IW'(r_req.dense_index);
    assign op_ok   = (r_req.req_type == ssm_pkg::REQ_CHANGE
                   || r_req.req_type == ssm_pkg::REQ_DESTROY)
                   && (32'(r_req.entity_id) < MAX_ENTITIES);

    // Clearing pass counter for the membership flags
    logic [IW-1:0] r_clr_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_cnt <= '0;
        else if (i_cmd.clr) r_clr_cnt <= r_clr_cnt + 1'b1;
    end
    assign o_stat.clr_last = (32'(r_clr_cnt) == MAX_ENTITIES - 1);

    logic [CW-1:0]  size_q [NS];
    logic [IW-1:0]  list_q [NS];
    logic [NS-1:0]  join_v, left_v, warn_v;

    // One sparse set bank per system
    for (genvar s = 0; s < NS; s++) begin : g_bank
        logic [IW:0]   slot_q, slot_wdata;
        logic [IW-1:0] slot_waddr, list_raddr, list_waddr, list_wdata, r_pos;
        logic          slot_we, list_we, now_in, was_in, do_ins, do_era, ins_ok, era_ok;
        logic          en;
        logic          r_ins, r_era, r_join, r_left, r_warn;
        logic [CW-1:0] r_size;

        assign en     = (s < ssm_pkg::MASK_W) ? r_enable[s % ssm_pkg::MASK_W] : 1'b0;
        assign now_in = ((r_req.new_signature & sig_keep & r_sig[s]) == r_sig[s]);
        assign was_in = ((r_req.old_signature & sig_keep & r_sig[s]) == r_sig[s]);
        assign do_ins = op_ok && en && r_req.req_type == ssm_pkg::REQ_CHANGE
                        && !was_in && now_in;
        assign do_era = op_ok && en && ((r_req.req_type == ssm_pkg::REQ_DESTROY) ? now_in
                        : (was_in && !now_in));
        assign ins_ok = do_ins && !slot_q[IW] && (32'(r_size) < MAX_ENTITIES);
        assign era_ok = do_era && slot_q[IW] && (r_size != '0);

        // Decide and register per bank action
        always_ff @(posedge i_clk) begin
            if (i_cmd.dec) begin
                r_ins  <= ins_ok;
                r_era  <= era_ok;
                r_join <= ins_ok;
                r_left <= era_ok;
                r_warn <= (do_ins && !ins_ok) || (do_era && !era_ok);
                r_pos  <= slot_q[IW-1:0];
            end
        end

        // Member count
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_size <= '0;
            end else if (i_cmd.wr1) begin
                if (r_ins) r_size <= r_size + 1'b1;
                else if (r_era) r_size <= r_size - 1'b1;
            end
        end

        assign size_q[s] = r_size;
        assign join_v[s] = r_join;
        assign left_v[s] = r_left;
        assign warn_v[s] = r_warn;

        // Flag and slot memory port control
        always_comb begin
            slot_we    = i_cmd.clr || (i_cmd.wr1 && (r_ins || r_era))
                         || (i_cmd.wr2 && r_era);
            slot_waddr = ent_ix;
            slot_wdata = '0;
            if (i_cmd.clr) begin
                slot_waddr = r_clr_cnt;
            end else if (i_cmd.wr1 && r_era) begin
                slot_waddr = list_q[s];
                slot_wdata = {1'b1, r_pos};
            end else if (i_cmd.wr1) begin
                slot_wdata = {1'b1, IW'(r_size)};
            end
        end

        // Dense list port control
        always_comb begin
            list_raddr = i_cmd.look ? didx_ix : IW'(r_size - 1'b1);
            list_we    = i_cmd.wr1 && (r_ins || r_era);
            list_waddr = r_ins ? IW'(r_size) : r_pos;
            list_wdata = r_ins ? ent_ix : list_q[s];
        end

        ssm_ram #(.WIDTH(IW + 1), .DEPTH(MAX_ENTITIES)) u_slot (
            .i_clk   (i_clk),
            .i_we    (slot_we),
            .i_waddr (slot_waddr),
            .i_wdata (slot_wdata),
            .i_raddr (ent_ix),
            .o_rdata (slot_q)
        );

        ssm_ram #(.WIDTH(IW), .DEPTH(MAX_ENTITIES)) u_list (
            .i_clk   (i_clk),
            .i_we    (list_we),
            .i_waddr (list_waddr),
            .i_wdata (list_wdata),
            .i_raddr (list_raddr),
            .o_rdata (list_q[s])
        );
    end

    // Read result captured when the dense entry arrives
    logic [ssm_pkg::ENT_W-1:0] r_rd_ent;
    logic                      r_rd_ok;
    logic [CW-1:0]             sel_size;
    logic [IW-1:0]             sel_list;
    logic                      sel_ok;

    always_comb begin
        sel_size = '0;
        sel_list = '0;
        sel_ok   = (32'(r_req.system_index) < NS);
        for (int s = 0; s < NS; s++) begin
            if (32'(r_req.system_index) == s) begin
                sel_size = size_q[s];
                sel_list = list_q[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dec) begin
            r_rd_ok  <= sel_ok && r_req.req_type == ssm_pkg::REQ_READ
                        && (32'(r_req.dense_index) < 32'(sel_size))
                        && (32'(r_req.dense_index) < MAX_ENTITIES);
            r_rd_ent <= ssm_pkg::ENT_W'(sel_list);
        end
    end

    // Output register
    logic         r_out_valid;
    ssm_pkg::t_out r_out;
    logic [ssm_pkg::MASK_W-1:0] join4, left4, warn4;

    always_comb begin
        for (int b = 0; b < ssm_pkg::MASK_W; b++) begin
            join4[b] = (b < NS) ? join_v[b % NS] : 1'b0;
            left4[b] = (b < NS) ? left_v[b % NS] : 1'b0;
            warn4[b] = (b < NS) ? warn_v[b % NS] : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.joined_mask  <= join4;
            r_out.left_mask    <= left4;
            r_out.warn_mask    <= warn4;
            r_out.read_entity  <= r_rd_ok ? r_rd_ent : '0;
            r_out.read_valid   <= r_rd_ok;
            r_out.member_count <= sel_ok ? ssm_pkg::COUNT_W'(sel_size) : '0;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/core/signature_sparse_set_membership.sv =====
`timescale 1ns / 1ps

// Sparse set membership per system slot, driven by component mask changes.
// Every request passes these steps from transfer in to result (look up the flag
// and slot memories, decide, fetch and write back the last dense entry,
// clear the removed entity's flag, load the result), in an order set by the
// single read and write port of each bank's slot and dense memories; all
// system banks work in parallel. The input is ready again in the cycle
// after the load; the next request is taken once the result has been
// loaded, and a finished result waits in an output register.
// After reset the block clears the membership flags of all MAX_ENTITIES
// entries and takes no request meanwhile; configuration writes are
// taken at any time and must only be done while idle.
module signature_sparse_set_membership #(
    parameter int MAX_ENTITIES   = ssm_pkg::DEF_MAX_ENTITIES,
    parameter int NUM_SYSTEMS    = ssm_pkg::DEF_NUM_SYSTEMS,
    parameter int SIGNATURE_BITS = ssm_pkg::DEF_SIGNATURE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ssm_pkg::t_in                  i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ssm_pkg::t_out                 o_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ssm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssm_pkg::SIG_W-1:0]     i_cfg_data
);

    ssm_pkg::t_cmd  cmd;
    ssm_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    ssm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ssm_dp #(
        .MAX_ENTITIES   (MAX_ENTITIES),
        .NUM_SYSTEMS    (NUM_SYSTEMS),
        .SIGNATURE_BITS (SIGNATURE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ===== rtl/core/ssm_checker.sv =====
`timescale 1ns / 1ps

module ssm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input ssm_pkg::t_out o_data
);

    // Result stays until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped or changed while stalled");

    // One request at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    // A system cannot both gain and lose, gain and warn, or lose and warn
    a_masks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.joined_mask & o_data.left_mask) == '0)
                 && ((o_data.joined_mask & o_data.warn_mask) == '0)
                 && ((o_data.left_mask & o_data.warn_mask) == '0))
        else $error("conflicting membership masks");

    // A read result carries no membership change
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.read_valid |-> o_data.joined_mask == '0
                 && o_data.left_mask == '0 && o_data.warn_mask == '0)
        else $error("read result with membership change");

endmodule

bind signature_sparse_set_membership ssm_checker u_ssm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
